// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL; only the transfer sequencer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, also while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/i2cms_pkg.sv -----
package i2cms_pkg;

    // Size of the write byte buffer loaded by a start word.
    localparam int WRITE_BUFFER_BYTES = 8;
    localparam logic [3:0] WBUF_LIMIT = 4'(WRITE_BUFFER_BYTES);
    localparam logic [7:0] WBUF_COUNT = 8'(WRITE_BUFFER_BYTES);

    // Operation codes of the command word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Bit positions in the status flags.
    localparam int FLAG_SB   = 0;
    localparam int FLAG_ADDR = 1;
    localparam int FLAG_TXE  = 2;
    localparam int FLAG_BTF  = 3;
    localparam int FLAG_RXNE = 4;
    localparam int FLAG_AF   = 5;

    typedef struct packed {
        logic        op;
        logic [6:0]  target_address;
        logic        direction;
        logic [7:0]  byte_count;
        logic [63:0] write_bytes;
        logic [5:0]  event_flags;
        logic [7:0]  data_reg_byte;
        logic [7:0]  shift_reg_byte;
    } cmd_word_t;

    typedef struct packed {
        logic       start_request;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] rx_count;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic       ack_enable;
        logic       pos_enable;
        logic       stop_request;
        logic       transfer_done;
        logic       transfer_failed;
    } res_word_t;

endpackage

// ----- rtl/i2cms_if.sv -----
// Command channel: one word per start or status event.
interface i2cms_cmd_if;
    logic                  valid;
    logic                  ready;
    i2cms_pkg::cmd_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one word per accepted command word.
interface i2cms_res_if;
    logic                  valid;
    logic                  ready;
    i2cms_pkg::res_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// Latency: a result word is valid the cycle after its command word is accepted.
// Throughput: one word per cycle; the single output register sets this figure,
// and cmd.ready drops only while a result waits with res.ready low.
// Reset (rst_n low, asynchronous): no result pending, read direction, address,
// count and write index zero, ACK level one, POS level zero.
`include "assert_macros.svh"

module i2c_master_transfer_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    i2cms_cmd_if.sink         cmd,
    i2cms_res_if.source       res
);

    logic                 is_write_reg, is_write_next;
    logic [6:0]           slave_addr_reg, slave_addr_next;
    logic [7:0]           bytes_left_reg, bytes_left_next;
    logic [3:0]           write_index_reg, write_index_next;
    logic [63:0]          write_buffer_reg;
    logic                 ack_level_reg, ack_level_next;
    logic                 pos_level_reg, pos_level_next;
    logic                 out_valid_reg;
    i2cms_pkg::res_word_t out_word_reg, out_word_next;

    logic                 accept;
    logic [5:0]           flags;
    logic [7:0]           buf_byte;
    logic [7:0]           start_count;

    // Accept whenever the output register is empty or being drained.
    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign flags     = cmd.data.event_flags;

    assign res.valid = out_valid_reg;
    assign res.data  = out_word_reg;

    // Next data byte from the buffer; past the buffer end it reads as zero.
    always_comb
    begin
        buf_byte = 8'h00;
        if (write_index_reg < i2cms_pkg::WBUF_LIMIT)
        begin
            buf_byte = write_buffer_reg[{write_index_reg[2:0], 3'b000} +: 8];
        end
    end

    // Write counts saturate at the buffer size; read counts pass as given.
    always_comb
    begin
        start_count = cmd.data.byte_count;
        if (cmd.data.direction && (cmd.data.byte_count > i2cms_pkg::WBUF_COUNT))
        begin
            start_count = i2cms_pkg::WBUF_COUNT;
        end
    end

    // Sequencer decode: one flag group is served per event, in priority order.
    always_comb
    begin
        is_write_next    = is_write_reg;
        slave_addr_next  = slave_addr_reg;
        bytes_left_next  = bytes_left_reg;
        write_index_next = write_index_reg;
        ack_level_next   = ack_level_reg;
        pos_level_next   = pos_level_reg;
        out_word_next    = '0;

        if (cmd.data.op == i2cms_pkg::OP_START)
        begin
            slave_addr_next             = cmd.data.target_address;
            is_write_next               = cmd.data.direction;
            bytes_left_next             = start_count;
            write_index_next            = 4'd0;
            ack_level_next              = 1'b1;
            pos_level_next              = 1'b0;
            out_word_next.start_request = 1'b1;
        end
        else if (flags[i2cms_pkg::FLAG_SB])
        begin
            // Address byte with the read/write bit in the LSB.
            out_word_next.tx_valid = 1'b1;
            out_word_next.tx_byte  = {slave_addr_reg, !is_write_reg};
            if (!is_write_reg)
            begin
                if (bytes_left_reg == 8'd2)
                begin
                    pos_level_next = 1'b1;
                    ack_level_next = 1'b0;
                end
                else if (bytes_left_reg == 8'd1)
                begin
                    ack_level_next = 1'b0;
                end
            end
        end
        else if (flags[i2cms_pkg::FLAG_ADDR])
        begin
            if (is_write_reg)
            begin
                if (bytes_left_reg != 8'd0)
                begin
                    out_word_next.tx_valid = 1'b1;
                    out_word_next.tx_byte  = buf_byte;
                    write_index_next       = write_index_reg + 4'd1;
                    bytes_left_next        = bytes_left_reg - 8'd1;
                end
            end
            else if (bytes_left_reg == 8'd1)
            begin
                ack_level_next = 1'b0;
            end
        end
        else if (flags[i2cms_pkg::FLAG_TXE] && flags[i2cms_pkg::FLAG_BTF])
        begin
            if (bytes_left_reg != 8'd0)
            begin
                out_word_next.tx_valid = 1'b1;
                out_word_next.tx_byte  = buf_byte;
                write_index_next       = write_index_reg + 4'd1;
                bytes_left_next        = bytes_left_reg - 8'd1;
            end
            else
            begin
                out_word_next.stop_request  = 1'b1;
                out_word_next.transfer_done = 1'b1;
                bytes_left_next             = 8'd0;
                write_index_next            = 4'd0;
                ack_level_next              = 1'b1;
                pos_level_next              = 1'b0;
            end
        end
        else if (flags[i2cms_pkg::FLAG_RXNE] && flags[i2cms_pkg::FLAG_BTF])
        begin
            if (bytes_left_reg > 8'd2)
            begin
                out_word_next.rx_count = 2'd1;
                out_word_next.rx_first = cmd.data.data_reg_byte;
                bytes_left_next        = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd3)
                begin
                    ack_level_next = 1'b0;
                    pos_level_next = 1'b1;
                end
            end
            else if (bytes_left_reg != 8'd0)
            begin
                // Last one or two bytes: deliver them and finish.
                out_word_next.rx_first      = cmd.data.data_reg_byte;
                out_word_next.rx_count      = 2'd1;
                if (bytes_left_reg == 8'd2)
                begin
                    out_word_next.rx_count  = 2'd2;
                    out_word_next.rx_second = cmd.data.shift_reg_byte;
                end
                out_word_next.stop_request  = 1'b1;
                out_word_next.transfer_done = 1'b1;
                bytes_left_next             = 8'd0;
                write_index_next            = 4'd0;
                ack_level_next              = 1'b1;
                pos_level_next              = 1'b0;
            end
        end
        else if (flags[i2cms_pkg::FLAG_AF])
        begin
            out_word_next.stop_request    = 1'b1;
            out_word_next.transfer_done   = 1'b1;
            out_word_next.transfer_failed = 1'b1;
            bytes_left_next               = 8'd0;
            write_index_next              = 4'd0;
            ack_level_next                = 1'b1;
            pos_level_next                = 1'b0;
        end

        out_word_next.ack_enable = ack_level_next;
        out_word_next.pos_enable = pos_level_next;
    end

    // Transfer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_write_reg    <= 1'b0;
            slave_addr_reg  <= 7'd0;
            bytes_left_reg  <= 8'd0;
            write_index_reg <= 4'd0;
            ack_level_reg   <= 1'b1;
            pos_level_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                is_write_reg    <= is_write_next;
                slave_addr_reg  <= slave_addr_next;
                bytes_left_reg  <= bytes_left_next;
                write_index_reg <= write_index_next;
                ack_level_reg   <= ack_level_next;
                pos_level_reg   <= pos_level_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: write buffer and result word.
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.data.op == i2cms_pkg::OP_START))
        begin
            write_buffer_reg <= cmd.data.write_bytes;
        end
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    `ASSERT_CLKD(a_accept_gives_result, accept |=> out_valid_reg, "accepted word produced no result")
    `ASSERT_ALWAYS(a_pos_needs_nack, pos_level_reg |-> !ack_level_reg, "POS set while ACK enabled")
    `ASSERT_ALWAYS(a_write_count_bound, is_write_reg |-> (bytes_left_reg <= i2cms_pkg::WBUF_COUNT), "write count above buffer size")
    `ASSERT_CLKD(a_fail_is_done, res.valid && res.data.transfer_failed |-> res.data.transfer_done && res.data.stop_request, "failure without finish")
    `ASSERT_CLKD(a_done_restores, res.valid && res.data.transfer_done |-> res.data.ack_enable && !res.data.pos_enable, "finish left ACK/POS levels")

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int WORDS_PER_PHASE = 590;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TIMEOUT_CYCLES  = 300000;
    localparam int MAX_REPORTS     = 10;

    // Status flag masks built from the bit positions in the package.
    localparam logic [5:0] EV_SB   = 6'b1 << i2cms_pkg::FLAG_SB;
    localparam logic [5:0] EV_ADDR = 6'b1 << i2cms_pkg::FLAG_ADDR;
    localparam logic [5:0] EV_TXE  = 6'b1 << i2cms_pkg::FLAG_TXE;
    localparam logic [5:0] EV_BTF  = 6'b1 << i2cms_pkg::FLAG_BTF;
    localparam logic [5:0] EV_RXNE = 6'b1 << i2cms_pkg::FLAG_RXNE;
    localparam logic [5:0] EV_AF   = 6'b1 << i2cms_pkg::FLAG_AF;

    typedef enum logic [1:0] {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_STEADY} phase_t;

    logic   clk = 1'b0;
    logic   rst_n;
    phase_t phase;
    int     src_idle_pct;
    int     sink_idle_pct;

    i2cms_cmd_if cmd_if ();
    i2cms_res_if res_if ();

    i2c_master_transfer_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Shadow copy of the transfer state.
    logic        seq_write;
    logic [6:0]  seq_addr;
    logic [7:0]  seq_left;
    logic [3:0]  seq_index;
    logic [63:0] seq_buffer;
    logic        seq_ack;
    logic        seq_pos;

    i2cms_pkg::cmd_word_t cmds_to_send[$];
    i2cms_pkg::res_word_t bus_actions_due[$];
    i2cms_pkg::res_word_t oldest_action;

    int words_queued;
    int results_checked;
    int mismatches;
    int cmd_stalls;
    int transfers_done;
    int transfers_failed;
    int hold_left;
    bit hold_done;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Loads the next data byte from the write buffer; past its end the byte is zero.
    function automatic void send_data_byte(inout i2cms_pkg::res_word_t r);
        r.tx_valid = 1'b1;
        r.tx_byte  = 8'h00;
        if (seq_index < i2cms_pkg::WBUF_LIMIT)
            r.tx_byte = seq_buffer[8 * seq_index +: 8];
        seq_index = seq_index + 4'd1;
        seq_left  = seq_left - 8'd1;
    endfunction

    // Finishing a transfer requests stop and returns ACK/POS to their idle levels.
    function automatic void end_transfer(inout i2cms_pkg::res_word_t r);
        r.stop_request  = 1'b1;
        r.transfer_done = 1'b1;
        seq_left  = 8'd0;
        seq_index = 4'd0;
        seq_ack   = 1'b1;
        seq_pos   = 1'b0;
    endfunction

    // Works out the bus action caused by one command word and advances the shadow state.
    function automatic i2cms_pkg::res_word_t next_bus_action(i2cms_pkg::cmd_word_t c);
        i2cms_pkg::res_word_t r;
        logic [7:0]           count;
        r = '0;
        if (c.op == i2cms_pkg::OP_START)
        begin
            count = c.byte_count;
            if (c.direction && count > i2cms_pkg::WBUF_COUNT)
                count = i2cms_pkg::WBUF_COUNT;
            seq_addr   = c.target_address;
            seq_write  = c.direction;
            seq_left   = count;
            seq_buffer = c.write_bytes;
            seq_index  = 4'd0;
            seq_ack    = 1'b1;
            seq_pos    = 1'b0;
            r.start_request = 1'b1;
        end
        else if (c.event_flags[i2cms_pkg::FLAG_SB])
        begin
            r.tx_valid = 1'b1;
            r.tx_byte  = {seq_addr, ~seq_write};
            if (!seq_write && seq_left == 8'd2)
            begin
                seq_pos = 1'b1;
                seq_ack = 1'b0;
            end
            else if (!seq_write && seq_left == 8'd1)
                seq_ack = 1'b0;
        end
        else if (c.event_flags[i2cms_pkg::FLAG_ADDR])
        begin
            if (seq_write && seq_left != 8'd0)
                send_data_byte(r);
            else if (!seq_write && seq_left == 8'd1)
                seq_ack = 1'b0;
        end
        else if (c.event_flags[i2cms_pkg::FLAG_TXE]
                 && c.event_flags[i2cms_pkg::FLAG_BTF])
        begin
            if (seq_left != 8'd0)
                send_data_byte(r);
            else
                end_transfer(r);
        end
        else if (c.event_flags[i2cms_pkg::FLAG_RXNE]
                 && c.event_flags[i2cms_pkg::FLAG_BTF])
        begin
            if (seq_left > 8'd2)
            begin
                r.rx_count = 2'd1;
                r.rx_first = c.data_reg_byte;
                seq_left   = seq_left - 8'd1;
                if (seq_left == 8'd2)
                begin
                    seq_ack = 1'b0;
                    seq_pos = 1'b1;
                end
            end
            else if (seq_left == 8'd2)
            begin
                r.rx_count  = 2'd2;
                r.rx_first  = c.data_reg_byte;
                r.rx_second = c.shift_reg_byte;
                end_transfer(r);
            end
            else if (seq_left == 8'd1)
            begin
                r.rx_count = 2'd1;
                r.rx_first = c.data_reg_byte;
                end_transfer(r);
            end
        end
        else if (c.event_flags[i2cms_pkg::FLAG_AF])
        begin
            end_transfer(r);
            r.transfer_failed = 1'b1;
        end
        r.ack_enable = seq_ack;
        r.pos_enable = seq_pos;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result word %0d: %s expected %0h, got %0h",
                         results_checked, name, want, got);
        end
    endfunction

    function automatic void compare_action(i2cms_pkg::res_word_t want,
                                           i2cms_pkg::res_word_t got);
        check_field("start_request", want.start_request, got.start_request);
        check_field("tx_valid", want.tx_valid, got.tx_valid);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("rx_count", want.rx_count, got.rx_count);
        check_field("rx_first", want.rx_first, got.rx_first);
        check_field("rx_second", want.rx_second, got.rx_second);
        check_field("ack_enable", want.ack_enable, got.ack_enable);
        check_field("pos_enable", want.pos_enable, got.pos_enable);
        check_field("stop_request", want.stop_request, got.stop_request);
        check_field("transfer_done", want.transfer_done, got.transfer_done);
        check_field("transfer_failed", want.transfer_failed, got.transfer_failed);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Sets the required flags plus a random choice among the harmless ones.
    function automatic logic [5:0] flags_with(logic [5:0] base, logic [5:0] extra);
        return base | (6'($urandom) & extra);
    endfunction

    // Start words carry random event fields, which the block must ignore.
    function automatic i2cms_pkg::cmd_word_t make_start(logic [6:0] addr,
                                                        logic dir_write,
                                                        logic [7:0] count,
                                                        logic [63:0] bytes);
        i2cms_pkg::cmd_word_t w;
        w.op             = i2cms_pkg::OP_START;
        w.target_address = addr;
        w.direction      = dir_write;
        w.byte_count     = count;
        w.write_bytes    = bytes;
        w.event_flags    = 6'($urandom);
        w.data_reg_byte  = rand_byte();
        w.shift_reg_byte = rand_byte();
        return w;
    endfunction

    // Event words carry random start fields, which the block must ignore.
    function automatic i2cms_pkg::cmd_word_t make_event(logic [5:0] flags, logic [7:0] dr,
                                                        logic [7:0] sr);
        i2cms_pkg::cmd_word_t w;
        w.op             = i2cms_pkg::OP_EVENT;
        w.target_address = 7'($urandom);
        w.direction      = 1'($urandom);
        w.byte_count     = rand_byte();
        w.write_bytes    = {$urandom, $urandom};
        w.event_flags    = flags;
        w.data_reg_byte  = dr;
        w.shift_reg_byte = sr;
        return w;
    endfunction

    function automatic void push_word(i2cms_pkg::cmd_word_t w);
        cmds_to_send.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_event(logic [5:0] flags);
        push_word(make_event(flags, rand_byte(), rand_byte()));
    endfunction

    task automatic queue_directed();
        // Empty write: no data byte after the address, the first tx empty finishes.
        push_word(make_start(7'h00, 1'b1, 8'd0, 64'd0));
        push_word(make_event(EV_SB, 8'h00, 8'h00));
        push_word(make_event(EV_ADDR, 8'h00, 8'h00));
        push_word(make_event(EV_TXE | EV_BTF, 8'h00, 8'h00));
        // Oversized write count saturates; with every flag set, start sent wins.
        push_word(make_start(7'h7F, 1'b1, 8'hFF, '1));
        push_word(make_event(6'h3F, 8'hFF, 8'hFF));
        push_word(make_event(EV_ADDR | EV_TXE | EV_BTF, 8'hFF, 8'hFF));
        push_word(make_event(EV_TXE | EV_BTF | EV_RXNE | EV_AF, 8'hFF, 8'hFF));
        push_word(make_event(EV_AF, 8'hFF, 8'hFF));
        // Two-byte read sets POS on start sent and takes both bytes at once.
        push_word(make_start(7'h55, 1'b0, 8'd2, 64'h0123_4567_89AB_CDEF));
        push_word(make_event(EV_SB, rand_byte(), rand_byte()));
        push_word(make_event(EV_ADDR, rand_byte(), rand_byte()));
        push_word(make_event(EV_RXNE | EV_BTF, 8'hFF, 8'h00));
        // One-byte read clears ACK early.
        push_word(make_start(7'h2A, 1'b0, 8'd1, {$urandom, $urandom}));
        push_word(make_event(EV_SB, rand_byte(), rand_byte()));
        push_word(make_event(EV_ADDR, rand_byte(), rand_byte()));
        push_word(make_event(EV_RXNE | EV_BTF, 8'h00, 8'hFF));
        // Idle cases: rx with nothing left, no flags, tx empty alone, tx empty at idle.
        push_word(make_event(EV_RXNE | EV_BTF, rand_byte(), rand_byte()));
        push_word(make_event(6'h00, rand_byte(), rand_byte()));
        push_word(make_event(EV_TXE, rand_byte(), rand_byte()));
        push_word(make_event(EV_TXE | EV_BTF, rand_byte(), rand_byte()));
        // Three-byte read drops into the POS phase after its first byte.
        push_word(make_start(7'h01, 1'b0, 8'd3, {$urandom, $urandom}));
        push_word(make_event(EV_SB, rand_byte(), rand_byte()));
        push_word(make_event(EV_ADDR, rand_byte(), rand_byte()));
        push_word(make_event(EV_RXNE | EV_BTF, 8'hA5, 8'h5A));
    endtask

    // One random transfer: mostly well-formed reads and writes, some broken or noisy.
    task automatic queue_random_transfer();
        int         kind;
        int         n_events;
        int         abort_at;
        logic [7:0] count;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            count = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 9))
                                              : 8'($urandom_range(8));
            push_word(make_start(7'($urandom), 1'b1, count, {$urandom, $urandom}));
            push_event(flags_with(EV_SB, 6'h3F));
            push_event(flags_with(EV_ADDR, ~EV_SB));
            if (count == 8'd0)
                n_events = 1;
            else
                n_events = (count > i2cms_pkg::WBUF_COUNT)
                           ? i2cms_pkg::WRITE_BUFFER_BYTES : int'(count);
            abort_at = ($urandom_range(9) == 0) ? $urandom_range(n_events - 1) : n_events;
            for (int k = 0; k < abort_at; k++)
                push_event(flags_with(EV_TXE | EV_BTF, EV_RXNE | EV_AF));
            if (abort_at < n_events)
                push_event(flags_with(EV_AF, EV_TXE | EV_RXNE));
        end
        else if (kind < 80)
        begin
            count = ($urandom_range(99) < 3) ? 8'($urandom_range(255, 11))
                                             : 8'($urandom_range(10));
            push_word(make_start(7'($urandom), 1'b0, count, {$urandom, $urandom}));
            push_event(flags_with(EV_SB, 6'h3F));
            push_event(flags_with(EV_ADDR, ~EV_SB));
            n_events = (count >= 8'd2) ? int'(count) - 1 : 1;
            abort_at = ($urandom_range(9) == 0) ? $urandom_range(n_events - 1) : n_events;
            for (int k = 0; k < abort_at; k++)
                push_event(flags_with(EV_RXNE | EV_BTF, EV_AF));
            if (abort_at < n_events || count == 8'd0)
                push_event(flags_with(EV_AF, EV_TXE | EV_RXNE));
        end
        else if (kind < 88)
        begin
            // Tx events during a long read run the buffer index past its end.
            count = 8'($urandom_range(20, 9));
            push_word(make_start(7'($urandom), 1'b0, count, {$urandom, $urandom}));
            push_event(flags_with(EV_SB, 6'h3F));
            n_events = $urandom_range(16, 9);
            for (int k = 0; k < n_events; k++)
                push_event(flags_with(EV_TXE | EV_BTF, EV_RXNE | EV_AF));
            push_event(EV_AF);
        end
        else
        begin
            n_events = $urandom_range(6, 1);
            for (int k = 0; k < n_events; k++)
            begin
                if ($urandom_range(4) == 0)
                    push_word(make_start(7'($urandom), 1'($urandom), rand_byte(),
                                         {$urandom, $urandom}));
                else
                    push_event(6'($urandom));
            end
        end
    endtask

    task automatic start_phase(phase_t p, int src_pct, int sink_pct);
        @(negedge clk);
        phase         = p;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    task automatic queue_phase_words();
        int target;
        target = words_queued + WORDS_PER_PHASE;
        while (words_queued < target)
            queue_random_transfer();
    endtask

    // The sender stays quiet until every queued word has been answered.
    task automatic wait_for_drain();
        while (cmds_to_send.size() != 0 || cmd_if.valid || bus_actions_due.size() != 0)
            @(posedge clk);
    endtask

    // Command driver: a word stays on the bus until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.data  <= '0;
        end
        else if (!cmd_if.valid || cmd_if.ready)
        begin
            if (cmds_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                cmd_if.valid <= 1'b1;
                cmd_if.data  <= cmds_to_send.pop_front();
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // Result acceptor, with one long hold-off at the start of the steady phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (phase == PH_STEADY && !hold_done)
        begin
            res_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Monitor: predict on each accepted command word, check each accepted result word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && !cmd_if.ready)
                cmd_stalls++;
            if (cmd_if.valid && cmd_if.ready)
                bus_actions_due.push_back(next_bus_action(cmd_if.data));
            if (res_if.valid && res_if.ready)
            begin
                if (bus_actions_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result word with nothing expected: %0h", res_if.data);
                end
                else
                begin
                    oldest_action = bus_actions_due.pop_front();
                    compare_action(oldest_action, res_if.data);
                    results_checked++;
                    if (oldest_action.transfer_done)
                        transfers_done++;
                    if (oldest_action.transfer_failed)
                        transfers_failed++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        res_if.ready  = 1'b0;
        phase         = PH_SLOW_SINK;
        src_idle_pct  = 27;
        sink_idle_pct = 70;
        seq_write     = 1'b0;
        seq_addr      = 7'd0;
        seq_left      = 8'd0;
        seq_index     = 4'd0;
        seq_buffer    = 64'd0;
        seq_ack       = 1'b1;
        seq_pos       = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        start_phase(PH_SLOW_SINK, 27, 70);
        queue_directed();
        queue_phase_words();
        wait_for_drain();

        start_phase(PH_SLOW_SOURCE, 70, 27);
        queue_phase_words();
        wait_for_drain();

        start_phase(PH_STEADY, 0, 0);
        queue_phase_words();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command words through three handshake phases; %0d results checked.",
                 words_queued, results_checked);
        $display("%0d transfers finished (%0d on ack failure), %0d command stalls, %0d errors.",
                 transfers_done, transfers_failed, cmd_stalls, mismatches);
        if (mismatches == 0 && bus_actions_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Timeout: %0d words unsent, %0d results outstanding.",
                 cmds_to_send.size(), bus_actions_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
